// ===== rtl/http_response_header_parser_unit_defines.svh =====
// Assertion macros shared by the parser RTL.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef HTTP_RESPONSE_HEADER_PARSER_UNIT_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_UNIT_DEFINES_SVH

// check with reset masking
`define HRHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also holds while reset is applied
`define HRHP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/hrhp_pkg.sv =====
// Shared types, constants and key tables for the HTTP response header parser.
// No dependencies.
package hrhp_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int LINE_LIMIT  = 320;
  localparam int POS_W       = $clog2(LINE_LIMIT + 1);
  localparam int NUM_W       = LENGTH_BITS;

  localparam logic [POS_W-1:0] LINE_LIMIT_POS = POS_W'(LINE_LIMIT);
  localparam logic [POS_W-1:0] STATUS_KEY_LEN = POS_W'(4);
  localparam logic [POS_W-1:0] LENGTH_KEY_LEN = POS_W'(16);
  localparam logic [POS_W-1:0] STATUS_OFFSET  = POS_W'(9);
  localparam logic [POS_W-1:0] LENGTH_OFFSET  = POS_W'(16);

  localparam logic [15:0] OK_CODE  = 16'd200;
  localparam logic [15:0] CODE_MAX = 16'hFFFF;
  localparam logic [2:0]  END_RUN  = 3'd4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_ACCEPT = 3'd1;
  localparam logic [2:0] EV_REJECT = 3'd2;
  localparam logic [2:0] EV_LENGTH = 3'd3;
  localparam logic [2:0] EV_END    = 3'd4;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } num_phase_t;

  typedef enum logic [2:0] {
    FIN_PARSE  = 3'b001,
    FIN_END    = 3'b010,
    FIN_REJECT = 3'b100
  } fin_state_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] status_code;
    logic [31:0] content_len;
    logic        length_known;
  } hrhp_res_t;

  function automatic logic [7:0] status_key_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h48; // H
      2'd1:    ch = 8'h54; // T
      2'd2:    ch = 8'h54; // T
      default: ch = 8'h50; // P
    endcase
    return ch;
  endfunction

  // "Content-Length: "
  function automatic logic [7:0] length_key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h4C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      4'd14:   ch = 8'h3A;
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/hrhp_parse_core.sv =====
// Per-byte parse state and its combinational next-state update.
// Depends on hrhp_pkg and http_response_header_parser_unit_defines.svh.
`include "http_response_header_parser_unit_defines.svh"

module hrhp_parse_core
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       new_response,
  output hrhp_res_t  res
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               sok_r, sok_nxt;
  logic               lok_r, lok_nxt;
  num_phase_t         ph_r, ph_nxt;
  logic [NUM_W-1:0]   nv_r, nv_nxt;
  logic [15:0]        code_r, code_nxt;
  logic [NUM_W-1:0]   len_r, len_nxt;
  logic               seen_r, seen_nxt;
  logic [2:0]         run_r, run_nxt;
  fin_state_t         fin_r, fin_nxt;
  logic [2:0]         ev;

  logic [NUM_W-1:0]   nv_base;
  logic [NUM_W+3:0]   acc;
  logic [NUM_W-1:0]   acc_sat;
  logic [15:0]        code_sat;
  logic               is_eol;
  logic               is_digit;
  logic               is_tab_blank;
  logic               num_go;
  logic               blank;

  assign nv_base  = new_response ? '0 : nv_r;
  assign is_eol   = (data_byte == CH_LF) || (data_byte == CH_CR);
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_tab_blank = (data_byte == CH_TAB) || (data_byte == CH_VT) || (data_byte == CH_FF);

  // value*10 + digit; any carry past NUM_W bits means saturation
  assign acc = {nv_base, 3'b000} + {2'b00, nv_base, 1'b0}
             + (NUM_W+4)'(data_byte - CH_ZERO);
  assign acc_sat  = (acc[NUM_W+3:NUM_W] != 4'd0) ? '1 : acc[NUM_W-1:0];
  assign code_sat = (nv_base > NUM_W'(CODE_MAX)) ? CODE_MAX : nv_base[15:0];

  always_comb begin
    pos_nxt  = pos_r;
    sok_nxt  = sok_r;
    lok_nxt  = lok_r;
    ph_nxt   = ph_r;
    nv_nxt   = nv_base;
    code_nxt = code_r;
    len_nxt  = len_r;
    seen_nxt = seen_r;
    run_nxt  = run_r;
    fin_nxt  = fin_r;
    ev       = EV_NONE;
    num_go   = 1'b0;
    blank    = 1'b0;

    if (new_response) begin
      pos_nxt  = '0;
      sok_nxt  = 1'b1;
      lok_nxt  = 1'b1;
      ph_nxt   = PH_SKIP;
      code_nxt = '0;
      len_nxt  = '0;
      seen_nxt = 1'b0;
      run_nxt  = '0;
      fin_nxt  = FIN_PARSE;
    end

    if (fin_nxt == FIN_PARSE) begin
      if (is_eol) begin
        if (sok_nxt && (pos_nxt >= STATUS_KEY_LEN)) begin
          code_nxt = code_sat;
          if (code_sat == OK_CODE) begin
            ev = EV_ACCEPT;
          end else begin
            ev      = EV_REJECT;
            fin_nxt = FIN_REJECT;
          end
        end else if (lok_nxt && (pos_nxt >= LENGTH_KEY_LEN)) begin
          len_nxt  = nv_base;
          seen_nxt = 1'b1;
          ev       = EV_LENGTH;
        end
        if (fin_nxt == FIN_PARSE) begin
          if (run_nxt < END_RUN) begin
            run_nxt = 3'(run_nxt + 3'd1);
          end
          if (run_nxt >= END_RUN) begin
            fin_nxt = FIN_END;
            ev      = EV_END;
          end
        end
        pos_nxt = '0;
        sok_nxt = 1'b1;
        lok_nxt = 1'b1;
        ph_nxt  = PH_SKIP;
        nv_nxt  = '0;
      end else begin
        run_nxt = '0;
        if ((pos_nxt < STATUS_KEY_LEN) && (data_byte != status_key_char(pos_nxt[1:0]))) begin
          sok_nxt = 1'b0;
        end
        if ((pos_nxt < LENGTH_KEY_LEN) && (data_byte != length_key_char(pos_nxt[3:0]))) begin
          lok_nxt = 1'b0;
        end
        num_go = (sok_nxt && (pos_nxt >= STATUS_OFFSET))
              || (lok_nxt && !sok_nxt && (pos_nxt >= LENGTH_OFFSET));
        // a plain space only counts as a blank on the length line
        blank  = is_tab_blank || ((data_byte == CH_SPACE) && !sok_nxt);
        if (num_go) begin
          if ((ph_nxt == PH_SKIP) && !blank) begin
            ph_nxt = PH_DIGITS;
          end
          if (ph_nxt == PH_DIGITS) begin
            if (is_digit) begin
              nv_nxt = acc_sat;
            end else begin
              ph_nxt = PH_DONE;
            end
          end
        end
        if (pos_nxt < LINE_LIMIT_POS) begin
          pos_nxt = POS_W'(pos_nxt + POS_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sok_r  <= 1'b1;
      lok_r  <= 1'b1;
      ph_r   <= PH_SKIP;
      nv_r   <= '0;
      code_r <= '0;
      len_r  <= '0;
      seen_r <= 1'b0;
      run_r  <= '0;
      fin_r  <= FIN_PARSE;
    end else if (step_en) begin
      pos_r  <= pos_nxt;
      sok_r  <= sok_nxt;
      lok_r  <= lok_nxt;
      ph_r   <= ph_nxt;
      nv_r   <= nv_nxt;
      code_r <= code_nxt;
      len_r  <= len_nxt;
      seen_r <= seen_nxt;
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
    end
  end

  assign res.event_res    = ev;
  assign res.status_code  = code_nxt;
  assign res.content_len  = 32'(len_nxt);
  assign res.length_known = seen_nxt;

  `HRHP_ASSERT(a_run_bounded, run_r <= END_RUN, "terminator run past limit")
  `HRHP_ASSERT(a_done_quiet, (step_en && !new_response && (fin_r != FIN_PARSE)) |-> (ev == EV_NONE), "event after parse ended")
  `HRHP_ASSERT(a_seen_clear, ($past(rst_n) && $fell(seen_r)) |-> $past(step_en && new_response), "length flag dropped without new response")
  `HRHP_ASSERT(a_line_pos, pos_r <= LINE_LIMIT_POS, "line position past limit")

endmodule

// ===== rtl/http_response_header_parser_unit.sv =====
// Top level of the HTTP response header parser: input word register, parse core, result register.
// Depends on hrhp_pkg, hrhp_parse_core and http_response_header_parser_unit_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_stall): one response byte per word, with in_new_response
//   set on the first byte of a response to clear all parse state before that byte.
//   Result channel (out_valid/out_stall): exactly one result word per input word, in order:
//   out_event_res (none, status 200, status rejected, length taken, header end), the last
//   status code, the last Content-Length value and whether one was seen.
//   Each accepted word passes through the input word register and then the result register
//   before its result shows at out_*.
//   Throughput: one byte per cycle while the receiver does not stall; the whole per-byte update
//   of the parse registers is combinational logic between the input word and result registers.
//   Reset (rst_n low, synchronous) empties both registers and returns the parser to its
//   start state, the same as a word with in_new_response set.
//   When the receiver stalls, the result word holds; one more byte waits in the input
//   register and in_stall rises only once that register is also full.
`include "http_response_header_parser_unit_defines.svh"

module http_response_header_parser_unit
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_new_response,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_status_code,
  output logic [31:0] out_content_len,
  output logic        out_length_known
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_data_r;
  logic       s1_new_r;
  logic       out_valid_r, out_valid_nxt;
  hrhp_res_t  out_res_r;
  hrhp_res_t  core_res;
  logic       out_free;
  logic       advance;
  logic       in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  hrhp_parse_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .data_byte    (s1_data_r),
    .new_response (s1_new_r),
    .res          (core_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data_byte;
      s1_new_r  <= in_new_response;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_res_r.event_res;
  assign out_status_code  = out_res_r.status_code;
  assign out_content_len  = out_res_r.content_len;
  assign out_length_known = out_res_r.length_known;

  `HRHP_ASSERT(a_stall_full, in_stall |-> (s1_valid_r && out_valid_r), "stall with room to spare")
  `HRHP_ASSERT(a_out_source, ($past(rst_n) && $rose(out_valid_r)) |-> $past(s1_valid_r), "result without input word")
  `HRHP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> (!s1_valid_r && !out_valid_r), "registers not empty after reset")

endmodule
